// ===== hw/rtl/nct_pkg.sv =====
// Package for the netlist character tokenizer: result record, codes and character classes.
package nct_pkg;

    // Default sizing of the column and line counters
    localparam int unsigned MAX_COLS_DEF  = 4096;
    localparam int unsigned MAX_LINES_DEF = 65535;

    // Result queue depth (power of two, at least two)
    localparam int unsigned RES_DEPTH = 4;

    // Field widths of one result
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ERR_W   = 2;
    localparam int unsigned LINE_W  = 16;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;
    localparam int unsigned CHR_W   = 8;
    localparam int unsigned TDATA_W = 56;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NAME   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_SLASH   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_INVALID = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NAME    = 3'd1,
        MODE_NUM     = 3'd2,
        MODE_SLASH   = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_FAILED  = 3'd5
    } mode_t;

    // One result record
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ERR_W-1:0]   err_code;
        logic [LINE_W-1:0]  line_number;
        logic [START_W-1:0] start_col;
        logic [LEN_W-1:0]   tok_len;
        logic [CHR_W-1:0]   single_char;
        logic               last;
    } result_t;

    // Results raised by one input character, first in r0
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } lex_res_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == CH_LPAR || c == CH_RPAR || c == CH_LBRK || c == CH_RBRK ||
               c == CH_COLON || c == CH_SEMI || c == CH_COMMA;
    endfunction

    function automatic logic is_name_cont(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == CH_USCORE || c == CH_DOLLAR;
    endfunction

endpackage

// ===== hw/rtl/nct_lexer.sv =====
// Tokenizer state and per-character decode producing up to two results.
module nct_lexer #(
    parameter int unsigned MAX_COLS  = nct_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_LINES = nct_pkg::MAX_LINES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             take,
    input  logic [7:0]       ch,
    input  logic             eol,
    output nct_pkg::lex_res_t res
);

    localparam int unsigned CCW = $clog2(MAX_COLS + 1);
    localparam int unsigned TSW = $clog2(MAX_COLS);
    localparam int unsigned LCW = $clog2(MAX_LINES + 1);

    nct_pkg::mode_t   mode_reg, mode_next;
    logic [TSW-1:0]   tok_start_reg, tok_start_next;
    logic [CCW-1:0]   col_count_reg, col_count_next;
    logic [LCW-1:0]   line_count_reg, line_count_next;

    logic [TSW-1:0]   col;
    logic [CCW-1:0]   pend_len;
    logic             continues;
    logic             pend_v, start_v;
    nct_pkg::result_t pend_r, start_r;

    // Clamped column and length of the pending token
    assign col = (col_count_reg > CCW'(MAX_COLS - 1)) ? TSW'(MAX_COLS - 1)
                                                       : TSW'(col_count_reg);
    assign pend_len = (col_count_reg > CCW'(tok_start_reg))
                      ? col_count_reg - CCW'(tok_start_reg) : CCW'(1);
    assign continues = (mode_reg == nct_pkg::MODE_NAME && nct_pkg::is_name_cont(ch)) ||
                       (mode_reg == nct_pkg::MODE_NUM && nct_pkg::is_digit(ch));

    // Next state
    always_comb begin
        mode_next       = mode_reg;
        tok_start_next  = tok_start_reg;
        col_count_next  = col_count_reg;
        line_count_next = line_count_reg;
        if (mode_reg != nct_pkg::MODE_FAILED) begin
            if (eol) begin
                unique case (mode_reg)
                    nct_pkg::MODE_SLASH: mode_next = nct_pkg::MODE_FAILED;
                    default:             mode_next = nct_pkg::MODE_IDLE;
                endcase
                if (mode_next != nct_pkg::MODE_FAILED) begin
                    col_count_next = '0;
                    if (line_count_reg < LCW'(MAX_LINES))
                        line_count_next = line_count_reg + LCW'(1);
                end
            end else begin
                unique case (mode_reg)
                    nct_pkg::MODE_SLASH: begin
                        mode_next = (ch == nct_pkg::CH_SLASH) ? nct_pkg::MODE_COMMENT
                                                              : nct_pkg::MODE_FAILED;
                    end
                    nct_pkg::MODE_COMMENT: ;
                    nct_pkg::MODE_IDLE, nct_pkg::MODE_NAME, nct_pkg::MODE_NUM: begin
                        if (!continues) begin
                            if (ch == nct_pkg::CH_SLASH) begin
                                mode_next      = nct_pkg::MODE_SLASH;
                                tok_start_next = col;
                            end else if (nct_pkg::is_blank(ch) || nct_pkg::is_punct(ch)) begin
                                mode_next = nct_pkg::MODE_IDLE;
                            end else if (nct_pkg::is_letter(ch) || ch == nct_pkg::CH_USCORE) begin
                                mode_next      = nct_pkg::MODE_NAME;
                                tok_start_next = col;
                            end else if (nct_pkg::is_digit(ch)) begin
                                mode_next      = nct_pkg::MODE_NUM;
                                tok_start_next = col;
                            end else begin
                                mode_next = nct_pkg::MODE_FAILED;
                            end
                        end
                    end
                    default: ;
                endcase
                if (mode_next != nct_pkg::MODE_FAILED && col_count_reg < CCW'(MAX_COLS))
                    col_count_next = col_count_reg + CCW'(1);
            end
        end
    end

    // Results: pending token first, then the token of this character
    always_comb begin
        pend_r             = '0;
        pend_r.kind        = (mode_reg == nct_pkg::MODE_NAME) ? nct_pkg::KIND_NAME
                                                              : nct_pkg::KIND_NUMBER;
        pend_r.err_code    = nct_pkg::ERR_NONE;
        pend_r.line_number = nct_pkg::LINE_W'(line_count_reg);
        pend_r.start_col   = nct_pkg::START_W'(tok_start_reg);
        pend_r.tok_len     = nct_pkg::LEN_W'(pend_len);
        pend_v             = 1'b0;

        start_r             = '0;
        start_r.line_number = nct_pkg::LINE_W'(line_count_reg);
        start_r.tok_len     = nct_pkg::LEN_W'(1);
        start_v             = 1'b0;

        if (mode_reg != nct_pkg::MODE_FAILED) begin
            if (eol) begin
                unique case (mode_reg)
                    nct_pkg::MODE_NAME, nct_pkg::MODE_NUM: pend_v = 1'b1;
                    nct_pkg::MODE_SLASH: begin
                        start_v           = 1'b1;
                        start_r.kind      = nct_pkg::KIND_ERROR;
                        start_r.err_code  = nct_pkg::ERR_SLASH;
                        start_r.start_col = nct_pkg::START_W'(tok_start_reg);
                    end
                    default: ;
                endcase
            end else begin
                unique case (mode_reg)
                    nct_pkg::MODE_SLASH: begin
                        if (ch != nct_pkg::CH_SLASH) begin
                            start_v           = 1'b1;
                            start_r.kind      = nct_pkg::KIND_ERROR;
                            start_r.err_code  = nct_pkg::ERR_SLASH;
                            start_r.start_col = nct_pkg::START_W'(tok_start_reg);
                        end
                    end
                    nct_pkg::MODE_IDLE, nct_pkg::MODE_NAME, nct_pkg::MODE_NUM: begin
                        if (!continues) begin
                            pend_v            = (mode_reg != nct_pkg::MODE_IDLE);
                            start_r.start_col = nct_pkg::START_W'(col);
                            if (nct_pkg::is_punct(ch)) begin
                                start_v             = 1'b1;
                                start_r.kind        = nct_pkg::KIND_SINGLE;
                                start_r.err_code    = nct_pkg::ERR_NONE;
                                start_r.single_char = ch;
                            end else if (!(ch == nct_pkg::CH_SLASH || nct_pkg::is_blank(ch) ||
                                           nct_pkg::is_letter(ch) || ch == nct_pkg::CH_USCORE ||
                                           nct_pkg::is_digit(ch))) begin
                                start_v          = 1'b1;
                                start_r.kind     = nct_pkg::KIND_ERROR;
                                start_r.err_code = nct_pkg::ERR_INVALID;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        // Order the results and flag the final one
        res.count = {1'b0, pend_v} + {1'b0, start_v};
        res.r0    = pend_v ? pend_r : start_r;
        res.r1    = start_r;
        res.r0.last = !(pend_v && start_v);
        res.r1.last = 1'b1;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= nct_pkg::MODE_IDLE;
            tok_start_reg  <= '0;
            col_count_reg  <= '0;
            line_count_reg <= LCW'(1);
        end else if (take) begin
            mode_reg       <= mode_next;
            tok_start_reg  <= tok_start_next;
            col_count_reg  <= col_count_next;
            line_count_reg <= line_count_next;
        end
    end

endmodule

// ===== hw/rtl/nct_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
module nct_res_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nct_pkg::lex_res_t wr,
    output logic              room,
    output logic              rd_valid,
    input  logic              rd_ready,
    output nct_pkg::result_t  rd_data
);

    localparam int unsigned DEPTH = nct_pkg::RES_DEPTH;
    localparam int unsigned PW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    nct_pkg::result_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_in;
    logic          pop;

    assign room     = count_reg <= CW'(DEPTH - 2);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;
    assign n_in     = push ? CW'(wr.count) : '0;

    // Pointer and fill arithmetic
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(n_in);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + n_in - CW'(pop);
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push && wr.count != 2'd0)
            mem[wr_ptr_reg] <= wr.r0;
        if (push && wr.count == 2'd2)
            mem[wr_ptr_reg + PW'(1)] <= wr.r1;
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/netlist_char_tokenizer.sv =====
// Top level of the netlist character tokenizer: lexer and result queue.
//
// One character (or an end-of-line marker on s_tlast) is taken per clock while the
// four-entry result queue has two free slots; the lexer decodes it in the same cycle
// and writes zero, one or two tokens into the queue, which hands them out one per
// transfer on the master side. A character that closes a name or number and is itself
// a token gives two results. Between two such characters there is always one that gave none,
// so while the receiver is ready the queue never holds more than two tokens and a
// character is taken on every clock; only receiver stalls hold the input back. A token
// appears on the master side at the earliest in the cycle after the character that raised
// it. After a lone slash or an invalid character an error token is sent and all
// further input is swallowed without results until reset.
module netlist_char_tokenizer #(
    parameter int unsigned MAX_COLS  = nct_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_LINES = nct_pkg::MAX_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // eol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] err_code, [17:2] line_number, [29:18] start_col,
                                   // [42:30] tok_len, [50:43] single_char, [55:51] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);

    nct_pkg::lex_res_t lex_res;
    nct_pkg::result_t  out_r;
    logic              take;

    assign take = s_tvalid && s_tready;

    nct_lexer #(
        .MAX_COLS  (MAX_COLS),
        .MAX_LINES (MAX_LINES)
    ) u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .ch      (s_tdata),
        .eol     (s_tlast),
        .res     (lex_res)
    );

    nct_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (take),
        .wr       (lex_res),
        .room     (s_tready),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_r)
    );

    // Output packing
    assign m_tdata = {5'd0, out_r.single_char, out_r.tok_len, out_r.start_col,
                      out_r.line_number, out_r.err_code};
    assign m_tuser = out_r.kind;
    assign m_tlast = out_r.last;

    // A transfer that raises results makes the output valid next cycle
    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && lex_res.count != 2'd0) |=> m_tvalid)
        else $error("results written but output not valid");

    // Two results only when a pending name or number closes first
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (lex_res.count == 2'd2) |->
            (lex_res.r0.kind == nct_pkg::KIND_NAME || lex_res.r0.kind == nct_pkg::KIND_NUMBER))
        else $error("result pair without a closing token first");

    // An error token is always the last of its character
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == nct_pkg::KIND_ERROR) |-> m_tlast)
        else $error("error token not marked last");

    // Non-error tokens carry no error code
    a_err_none: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != nct_pkg::KIND_ERROR) |-> (m_tdata[1:0] == nct_pkg::ERR_NONE))
        else $error("error code on a non-error token");

endmodule

// ===== tb/nct_checker.sv =====
// Checker for the netlist character tokenizer: predicts tokens from accepted characters
// and compares them with the result channel.
module nct_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [nct_pkg::TDATA_W-1:0] m_tdata,
    input  logic [1:0]                  m_tuser,
    input  logic                        m_tlast,
    output int                          mismatches,
    output int                          pending_tokens
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_CAP  = nct_pkg::MAX_COLS_DEF;
    localparam int LINE_CAP = nct_pkg::MAX_LINES_DEF;
    localparam int SHOW_MAX = 10;

    typedef enum logic [2:0] {
        CC_BLANK, CC_PUNCT, CC_ALPHA, CC_DIGIT, CC_USCORE, CC_DOLLAR, CC_SLASH, CC_OTHER
    } char_class_t;

    // Predicted lexer state
    nct_pkg::mode_t lex_mode;
    logic [11:0]    tok_start;
    logic [12:0]    col_cnt;
    logic [15:0]    line_cnt;

    nct_pkg::result_t tokens_due[$];
    int               shown;

    function automatic char_class_t classify(input logic [7:0] c);
        case (c)
            nct_pkg::CH_SPACE, nct_pkg::CH_TAB,
            nct_pkg::CH_CR, nct_pkg::CH_LF:       return CC_BLANK;
            nct_pkg::CH_LPAR, nct_pkg::CH_RPAR, nct_pkg::CH_LBRK, nct_pkg::CH_RBRK,
            nct_pkg::CH_COLON, nct_pkg::CH_SEMI,
            nct_pkg::CH_COMMA:                    return CC_PUNCT;
            nct_pkg::CH_USCORE:                   return CC_USCORE;
            nct_pkg::CH_DOLLAR:                   return CC_DOLLAR;
            nct_pkg::CH_SLASH:                    return CC_SLASH;
            default: begin
                if (c >= nct_pkg::CH_ZERO && c <= nct_pkg::CH_NINE)
                    return CC_DIGIT;
                if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                    return CC_ALPHA;
                return CC_OTHER;
            end
        endcase
    endfunction

    function automatic nct_pkg::result_t make_tok(input logic [1:0] k, input logic [1:0] e,
                                                  input logic [11:0] start,
                                                  input logic [12:0] len,
                                                  input logic [7:0] chr);
        nct_pkg::result_t t;
        t.kind        = k;
        t.err_code    = e;
        t.line_number = line_cnt;
        t.start_col   = start;
        t.tok_len     = len;
        t.single_char = chr;
        t.last        = 1'b0;
        return t;
    endfunction

    // Name or number that is still open
    function automatic nct_pkg::result_t open_tok();
        logic [12:0] len;
        len = (col_cnt > {1'b0, tok_start}) ? col_cnt - {1'b0, tok_start} : 13'd1;
        return make_tok((lex_mode == nct_pkg::MODE_NAME) ? nct_pkg::KIND_NAME
                                                         : nct_pkg::KIND_NUMBER,
                        nct_pkg::ERR_NONE, tok_start, len, 8'd0);
    endfunction

    function automatic string fmt_tok(input nct_pkg::result_t t);
        return $sformatf("kind %0d err %0d line %0d col %0d len %0d chr %02h last %0b",
                         t.kind, t.err_code, t.line_number, t.start_col, t.tok_len,
                         t.single_char, t.last);
    endfunction

    // Advance the lexer by one character or end of line, queue the tokens it raises
    task automatic lex_char(input logic [7:0] c, input logic eol);
        nct_pkg::result_t found[2];
        int               n;
        logic [11:0]      col;
        char_class_t      cc;
        n   = 0;
        col = (col_cnt > 13'(COL_CAP - 1)) ? 12'(COL_CAP - 1) : col_cnt[11:0];
        if (lex_mode == nct_pkg::MODE_FAILED)
            return;
        if (eol) begin
            if (lex_mode == nct_pkg::MODE_NAME || lex_mode == nct_pkg::MODE_NUM) begin
                found[n] = open_tok();
                n++;
                lex_mode = nct_pkg::MODE_IDLE;
            end else if (lex_mode == nct_pkg::MODE_SLASH) begin
                found[n] = make_tok(nct_pkg::KIND_ERROR, nct_pkg::ERR_SLASH, tok_start,
                                    13'd1, 8'd0);
                n++;
                lex_mode = nct_pkg::MODE_FAILED;
            end else begin
                lex_mode = nct_pkg::MODE_IDLE;
            end
            if (lex_mode != nct_pkg::MODE_FAILED) begin
                if (line_cnt < 16'(LINE_CAP))
                    line_cnt++;
                col_cnt = '0;
            end
        end else begin
            cc = classify(c);
            if (lex_mode == nct_pkg::MODE_SLASH) begin
                if (cc == CC_SLASH) begin
                    lex_mode = nct_pkg::MODE_COMMENT;
                end else begin
                    found[n] = make_tok(nct_pkg::KIND_ERROR, nct_pkg::ERR_SLASH, tok_start,
                                        13'd1, 8'd0);
                    n++;
                    lex_mode = nct_pkg::MODE_FAILED;
                end
            end else if (lex_mode == nct_pkg::MODE_COMMENT) begin
                // rest of the line is swallowed
            end else if (lex_mode == nct_pkg::MODE_NAME &&
                         cc inside {CC_ALPHA, CC_DIGIT, CC_USCORE, CC_DOLLAR}) begin
                // name grows
            end else if (lex_mode == nct_pkg::MODE_NUM && cc == CC_DIGIT) begin
                // number grows
            end else begin
                if (lex_mode == nct_pkg::MODE_NAME || lex_mode == nct_pkg::MODE_NUM) begin
                    found[n] = open_tok();
                    n++;
                end
                lex_mode = nct_pkg::MODE_IDLE;
                case (cc)
                    CC_SLASH: begin
                        lex_mode  = nct_pkg::MODE_SLASH;
                        tok_start = col;
                    end
                    CC_BLANK: ;
                    CC_PUNCT: begin
                        found[n] = make_tok(nct_pkg::KIND_SINGLE, nct_pkg::ERR_NONE, col,
                                            13'd1, c);
                        n++;
                    end
                    CC_ALPHA, CC_USCORE: begin
                        lex_mode  = nct_pkg::MODE_NAME;
                        tok_start = col;
                    end
                    CC_DIGIT: begin
                        lex_mode  = nct_pkg::MODE_NUM;
                        tok_start = col;
                    end
                    default: begin
                        found[n] = make_tok(nct_pkg::KIND_ERROR, nct_pkg::ERR_INVALID, col,
                                            13'd1, 8'd0);
                        n++;
                        lex_mode = nct_pkg::MODE_FAILED;
                    end
                endcase
            end
            if (lex_mode != nct_pkg::MODE_FAILED && col_cnt < 13'(COL_CAP))
                col_cnt++;
        end
        if (n > 0)
            found[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            tokens_due.insert(tokens_due.size(), found[i]);
    endtask

    // Compare one token off the result channel with the oldest prediction
    task automatic check_tok();
        nct_pkg::result_t got;
        nct_pkg::result_t want;
        got.kind        = m_tuser;
        got.err_code    = m_tdata[1:0];
        got.line_number = m_tdata[17:2];
        got.start_col   = m_tdata[29:18];
        got.tok_len     = m_tdata[42:30];
        got.single_char = m_tdata[50:43];
        got.last        = m_tlast;
        if (tokens_due.size() == 0) begin
            mismatches++;
            if (shown < SHOW_MAX)
                $display("%0t: token with none expected: %s", $realtime, fmt_tok(got));
            shown++;
            return;
        end
        want = tokens_due[0];
        tokens_due.delete(0);
        if (got.kind !== want.kind || got.err_code !== want.err_code ||
            got.line_number !== want.line_number || got.start_col !== want.start_col ||
            got.tok_len !== want.tok_len || got.single_char !== want.single_char ||
            got.last !== want.last) begin
            mismatches++;
            if (shown < SHOW_MAX)
                $display("%0t: token mismatch\n  expected %s\n  actual   %s",
                         $realtime, fmt_tok(want), fmt_tok(got));
            shown++;
        end
    endtask

    // Characters are predicted before tokens are checked, so a token is never early
    always @(posedge aclk) begin
        if (!aresetn) begin
            lex_mode  = nct_pkg::MODE_IDLE;
            tok_start = '0;
            col_cnt   = '0;
            line_cnt  = 16'd1;
            tokens_due.delete();
            mismatches = 0;
            shown      = 0;
        end else begin
            if (s_tvalid && s_tready)
                lex_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_tok();
        end
        pending_tokens = tokens_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the tokenizer testbench: clock, reset, character stimulus, receiver stalls, verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 400;

    logic                        aclk     = 1'b0;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic [7:0]                  s_tdata  = '0;
    logic                        s_tlast  = 1'b0;
    logic                        m_tready = 1'b0;
    wire                         s_tready;
    wire                         m_tvalid;
    wire  [nct_pkg::TDATA_W-1:0] m_tdata;
    wire  [1:0]                  m_tuser;
    wire                         m_tlast;

    int mismatches;
    int pending_tokens;

    // Traffic shaping
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_len  = 0;
    bit hold_go   = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int chars_sent = 0;
    int cyc = 0;

    string      head_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string      tail_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_$";
    logic [7:0] punct_set [7] = '{nct_pkg::CH_LPAR, nct_pkg::CH_RPAR, nct_pkg::CH_LBRK,
                                  nct_pkg::CH_RBRK, nct_pkg::CH_COLON, nct_pkg::CH_SEMI,
                                  nct_pkg::CH_COMMA};
    logic [7:0] blank_set [4] = '{nct_pkg::CH_SPACE, nct_pkg::CH_TAB, nct_pkg::CH_CR,
                                  nct_pkg::CH_LF};

    netlist_char_tokenizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    nct_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .pending_tokens (pending_tokens)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cyc < CYCLE_LIMIT) begin
            @(posedge aclk);
            cyc++;
        end
        $display("timeout after %0d cycles", cyc);
        $display("== FAIL ==");
        $finish;
    end

    // One transfer on the input side, after a random idle gap
    task automatic send_char(input logic [7:0] c, input logic eol);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input bit with_eol);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
        if (with_eol)
            send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Stop sending until every predicted token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_tokens != 0);
        @(posedge aclk);
    endtask

    // A well-formed line of random tokens, possibly ending in a comment
    task automatic random_line();
        int ntok;
        int pick;
        ntok = $urandom_range(0, 6);
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_char(head_chars[$urandom_range(0, head_chars.len() - 1)], 1'b0);
                repeat ($urandom_range(0, 11))
                    send_char(tail_chars[$urandom_range(0, tail_chars.len() - 1)], 1'b0);
            end else if (pick < 50) begin
                repeat ($urandom_range(1, 8))
                    send_char(nct_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end else if (pick < 70) begin
                send_char(punct_set[$urandom_range(0, 6)], 1'b0);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 3))
                    send_char(blank_set[$urandom_range(0, 3)], 1'b0);
            end else begin
                // comment body may hold any byte at all
                send_text("//", 1'b0);
                repeat ($urandom_range(0, 8))
                    send_char(8'($urandom_range(0, 255)), 1'b0);
                break;
            end
        end
        send_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_phase(input int idle, input int stall, input bit with_hold);
        int target;
        bit held;
        idle_pct  = idle;
        stall_pct = stall;
        target    = chars_sent + PHASE_ITEMS;
        held      = 1'b0;
        while (chars_sent < target) begin
            if (with_hold && !held && chars_sent >= target - PHASE_ITEMS / 2) begin
                // receiver stops for a long while, sender keeps pushing
                hold_len = HOLD_CYCLES;
                hold_go  = ~hold_go;
                held     = 1'b1;
            end
            random_line();
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: single, name and number tokens, both ways of closing a token, comment contents
        send_text("_Z$9 90[", 1'b1);
        send_text("q)1,z//", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("#", 1'b0);
        send_char(8'h00, 1'b1);
        send_text("]:;(\t", 1'b0);
        send_char(nct_pkg::CH_CR, 1'b0);
        send_char(nct_pkg::CH_LF, 1'b0);
        send_text("7", 1'b1);
        drain();

        // Random lines under the four traffic shapes
        run_phase(0, 0, 1'b1);
        run_phase(82, 0, 1'b0);
        run_phase(0, 82, 1'b0);
        run_phase(23, 23, 1'b0);

        // One fatal error, then input that must be swallowed
        idle_pct  = 23;
        stall_pct = 23;
        case ($urandom_range(0, 2))
            0: begin
                send_text("w/", 1'b0);
                send_char(head_chars[$urandom_range(0, head_chars.len() - 1)], 1'b0);
            end
            1: send_text("/", 1'b1);
            default: begin
                if ($urandom_range(0, 1))
                    send_char(8'($urandom_range(128, 255)), 1'b0);
                else
                    send_char(nct_pkg::CH_DOLLAR, 1'b0);
            end
        endcase
        repeat (20)
            send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && pending_tokens == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
